/* design/cdq_pkg.sv */
`timescale 1ns / 1ps

package cdq_pkg;

  // ring size and pointer width
  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;

  // request codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // access from the pointer control to the ring memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    idx_t addr;
  } mem_req_t;

  // pointer step forward with wrap at the last slot
  function automatic idx_t wrap_next(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // pointer step backward with wrap at slot zero
  function automatic idx_t wrap_prev(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

/* design/cdq_ram.sv */
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 3,
  parameter int WORDS  = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  // single port, registered read, read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/cdq_ctrl.sv */
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_take,
  input  op_t      req_op,
  output mem_req_t mem_req,
  output status_t  req_status
);

  idx_t front_r, front_nxt;
  idx_t rear_r, rear_nxt;
  logic empty_r, empty_nxt;
  logic full;

  assign full = !empty_r && (wrap_next(rear_r) == front_r);

  // pointer update, memory access and status for the request being taken
  always_comb begin
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    empty_nxt     = empty_r;
    mem_req.wr_en = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.addr  = front_r;
    req_status    = ST_DONE;
    unique case (req_op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full) begin
          req_status = ST_FULL;
        end else if (empty_r) begin
          front_nxt     = '0;
          rear_nxt      = '0;
          empty_nxt     = 1'b0;
          mem_req.wr_en = req_take;
          mem_req.addr  = '0;
        end else if (req_op == OP_PUSH_FRONT) begin
          front_nxt     = wrap_prev(front_r);
          mem_req.wr_en = req_take;
          mem_req.addr  = wrap_prev(front_r);
        end else begin
          rear_nxt      = wrap_next(rear_r);
          mem_req.wr_en = req_take;
          mem_req.addr  = wrap_next(rear_r);
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty_r) begin
          req_status = ST_EMPTY;
        end else begin
          mem_req.rd_en = req_take;
          mem_req.addr  = (req_op == OP_POP_FRONT) ? front_r : rear_r;
          if (front_r == rear_r) begin
            // last entry leaves, back to the reset pointers
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (req_op == OP_POP_FRONT) begin
            front_nxt = wrap_next(front_r);
          end else begin
            rear_nxt = wrap_prev(rear_r);
          end
        end
      end
      default: begin
        req_status = ST_DONE;
      end
    endcase
  end

  // pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
    end else if (req_take) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

/* design/circular_deque.sv */
`timescale 1ns / 1ps

// Double-ended queue of 32-bit signed words in a ring of DEPTH entries held in
// one single-port synchronous memory. Each request pushes at the front or rear
// or pops from the front or rear and yields exactly one result: the popped
// value with status done, zero with status done for an accepted push, or zero
// with status full (push refused) or empty (pop refused). A request is taken
// every cycle while the output register is free or being taken. Its result
// passes through the read stage: the memory read happens at the taking edge
// and the output register loads as the read stage moves on. Pointers update
// as the request is taken, so back-to-back requests to the same slot need no
// interlock.

module circular_deque import cdq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]         out_status
);

  mem_req_t          mem_req;
  status_t           req_status;
  logic [DATA_W-1:0] rd_data;
  logic              req_take;
  logic              move;

  logic              p_valid_r;
  logic              p_pop_r;
  status_t           p_status_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_pop_value_r;
  status_t           out_status_r;

  // read stage drains when the output register is free or being taken
  assign move     = !out_valid_r || !out_stall;
  assign in_stall = p_valid_r && !move;
  assign req_take = in_valid && !in_stall;

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_take   (req_take),
    .req_op     (op_t'(in_operation)),
    .mem_req    (mem_req),
    .req_status (req_status)
  );

  cdq_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .rd_en   (mem_req.rd_en),
    .addr    (mem_req.addr),
    .wr_data (in_push_value),
    .rd_data (rd_data)
  );

  // read stage: holds the taken request until it moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (req_take) begin
      p_valid_r <= 1'b1;
    end else if (move) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      p_pop_r    <= mem_req.rd_en;
      p_status_r <= req_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move && p_valid_r) begin
      out_pop_value_r <= p_pop_r ? rd_data : '0;
      out_status_r    <= p_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;

endmodule
